>>> sv/svp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared sizes, codes and types of the stride value predictor.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int ENTRIES   = 1024;            // power of two
    localparam int CONF_BITS = 2;
    localparam int ADDR_W    = 64;
    localparam int VAL_W     = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int TAG_W     = ADDR_W - IDX_W;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CONF_BITS-1:0] CONF_MAX = {CONF_BITS{1'b1}};

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] index;
        logic [TAG_W-1:0] tag;
        logic             was_predicted;
        logic             prediction_correct;
        logic [VAL_W-1:0] true_value;
    } t_req;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [CONF_BITS-1:0] conf;
        logic [VAL_W-1:0]     last_value;
        logic [VAL_W-1:0]     stride;
    } t_entry;

    // status from back to front
    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> sv/svp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_front
// Input stage: takes requests, splits the address into index and tag, and
// holds the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module svp_front
    import svp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_inst_addr,
    input  logic              i_was_predicted,
    input  logic              i_prediction_correct,
    input  logic [VAL_W-1:0]  i_true_value,
    input  t_back_stat        i_back_stat,
    input  logic              i_q_full,
    output logic              o_push,
    output t_req              o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_req;
    logic accept;

    assign o_stall = i_back_stat.clearing || (r_valid && i_q_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.action             <= i_action;
            r_req.index              <= i_inst_addr[IDX_W-1:0];
            r_req.tag                <= i_inst_addr[ADDR_W-1:IDX_W];
            r_req.was_predicted      <= i_was_predicted;
            r_req.prediction_correct <= i_prediction_correct;
            r_req.true_value         <= i_true_value;
        end
    end

endmodule

>>> sv/svp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module svp_queue
    import svp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_req o_head
);

    t_req              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_req;
        end
    end

endmodule

>>> sv/svp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_back
// Table engine: clears the table after reset, then runs each request as a
// read of one entry, plus a write back on updates, and drives the result register.
// ----------------------------------------------------------------------------
module svp_back
    import svp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  t_req             i_head,
    output logic             o_pop,
    output t_back_stat       o_stat,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_predict_valid,
    output logic [VAL_W-1:0] o_predicted_value
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    t_entry r_mem [ENTRIES];
    t_entry r_rd;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_clr_idx;
    t_req             r_req;

    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_pv;
    logic [VAL_W-1:0] r_out_val;

    logic             out_free;
    logic             exec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;
    t_entry           upd;
    logic             tag_hit;
    logic [CONF_BITS-1:0] conf_inc;
    logic             pred;
    logic [VAL_W-1:0] pred_val;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_head_valid && out_free;
    assign exec     = (r_state == ST_EXEC);
    assign o_stat.clearing = (r_state == ST_CLEAR);

    // entry evaluation on the registered read data
    assign tag_hit  = (r_rd.tag == r_req.tag);
    assign conf_inc = (r_rd.conf == CONF_MAX) ? CONF_MAX : r_rd.conf + CONF_BITS'(1);
    assign pred     = (r_req.action == ACT_LOOKUP) && (r_rd.conf == CONF_MAX) && tag_hit;
    assign pred_val = pred ? (r_rd.last_value + r_rd.stride) : '0;

    always_comb begin
        upd            = r_rd;
        upd.last_value = r_req.true_value;
        upd.stride     = r_req.true_value - r_rd.last_value;
        if (r_req.was_predicted) begin
            upd.conf = r_req.prediction_correct ? conf_inc : '0;
        end else if (tag_hit) begin
            upd.conf = conf_inc;
        end else begin
            upd.tag  = r_req.tag;
            upd.conf = '0;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_req.index;
        wr_data = upd;
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_idx  = r_clr_idx;
            wr_data = '0;
        end else if (exec && (r_req.action == ACT_UPDATE)) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == {IDX_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // the result register is known empty in the execute cycle
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (exec) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_head;
        end
        if (exec) begin
            r_out_pv  <= pred;
            r_out_val <= pred_val;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[i_head.index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_predict_valid   = r_out_pv;
    assign o_predicted_value = r_out_val;

endmodule

>>> sv/stride_value_predictor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stride_value_predictor_core
// Direct-mapped, tagged stride value predictor: lookups and updates.
// ----------------------------------------------------------------------------
// Each request (lookup or update) returns exactly one result. After reset the
// table is cleared one entry per cycle, so input stall stays high until the
// clear is done. Then one request runs at a time: the table is a single-port
// memory and each request is a read of its entry followed, for an update, by
// a write in the next cycle. A request passes the input register, the queue,
// the table read and evaluation into the result register. The input register
// and two-deep queue keep taking requests while a result waits to be taken.
module stride_value_predictor_core
    import svp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_inst_addr,
    input  logic              i_was_predicted,
    input  logic              i_prediction_correct,
    input  logic [VAL_W-1:0]  i_true_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_predict_valid,
    output logic [VAL_W-1:0]  o_predicted_value
);

    t_back_stat back_stat;
    logic       q_full;
    logic       push;
    t_req       push_req;
    logic       pop;
    logic       head_valid;
    t_req       head;

    svp_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_action             (i_action),
        .i_inst_addr          (i_inst_addr),
        .i_was_predicted      (i_was_predicted),
        .i_prediction_correct (i_prediction_correct),
        .i_true_value         (i_true_value),
        .i_back_stat          (back_stat),
        .i_q_full             (q_full),
        .o_push               (push),
        .o_req                (push_req)
    );

    svp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_req        (push_req),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    svp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head_valid      (head_valid),
        .i_head            (head),
        .o_pop             (pop),
        .o_stat            (back_stat),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_predict_valid   (o_predict_valid),
        .o_predicted_value (o_predicted_value)
    );

endmodule

>>> sv/svp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_checker
// Port-level checks of the stride value predictor, bound to the top level.
// ----------------------------------------------------------------------------
module svp_checker
    import svp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_stall,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_predict_valid,
    input  logic [VAL_W-1:0]  o_predicted_value
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // no prediction means a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_predict_valid |-> o_predicted_value == '0)
        else $error("nonzero value without prediction");

    // reset starts the table clear: no requests taken, no results shown
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("request path open right after reset");

    // one request in the engine at a time: a taken result is never replaced at once
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back results from the table engine");

endmodule

bind stride_value_predictor_core svp_checker u_svp_checker (.*);

>>> tb/tb_stride_value_predictor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stride_value_predictor_core
// Self-checking bench for the stride value predictor core. A directed table
// covers the fresh table, saturation, wraparound and tag replacement. Random
// stride runs follow, with lookups and well-formed updates and some noise.
// Every result is compared against a local model of the table or, for typed
// directed rows, their given result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stride_value_predictor_core;
    import svp_pkg::*;

    localparam int RAND_ITEMS = 850;
    localparam int POOL_N     = 12;

    typedef struct packed {
        logic             action;
        logic [ADDR_W-1:0] addr;
        logic             wp;
        logic             pc;
        logic [VAL_W-1:0] tv;
    } t_vp_req;

    typedef struct packed {
        logic             pv;
        logic [VAL_W-1:0] val;
    } t_vp_result;

    typedef struct packed {
        t_vp_req    rq;
        logic       typed;
        t_vp_result res;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_action;
    logic [ADDR_W-1:0] i_inst_addr;
    logic              i_was_predicted;
    logic              i_prediction_correct;
    logic [VAL_W-1:0]  i_true_value;
    logic              o_valid;
    logic              i_stall;
    logic              o_predict_valid;
    logic [VAL_W-1:0]  o_predicted_value;

    stride_value_predictor_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_action             (i_action),
        .i_inst_addr          (i_inst_addr),
        .i_was_predicted      (i_was_predicted),
        .i_prediction_correct (i_prediction_correct),
        .i_true_value         (i_true_value),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_predict_valid      (o_predict_valid),
        .o_predicted_value    (o_predicted_value)
    );

    // model of the table
    logic [TAG_W-1:0]     pt_tag    [ENTRIES];
    logic [CONF_BITS-1:0] pt_conf   [ENTRIES];
    logic [VAL_W-1:0]     pt_last   [ENTRIES];
    logic [VAL_W-1:0]     pt_stride [ENTRIES];

    t_vp_result  pending_results [$];
    t_dir_row    dir_tab [$];
    int          mismatch_count = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("stride_value_predictor_core verification failed");
        $finish;
    end

    function automatic logic [CONF_BITS-1:0] conf_bump(input logic [CONF_BITS-1:0] c);
        return (c == CONF_MAX) ? CONF_MAX : c + 1'b1;
    endfunction

    function automatic t_vp_result stride_table_lookup(input logic [ADDR_W-1:0] addr);
        t_vp_result       r;
        logic [IDX_W-1:0] ix;
        ix = addr[IDX_W-1:0];
        r  = '0;
        if (pt_conf[ix] == CONF_MAX && pt_tag[ix] == addr[ADDR_W-1:IDX_W]) begin
            r.pv  = 1'b1;
            r.val = pt_last[ix] + pt_stride[ix];
        end
        return r;
    endfunction

    // result of one request; trains the table on updates
    function automatic t_vp_result stride_table_step(input t_vp_req rq);
        t_vp_result       r;
        logic [IDX_W-1:0] ix;
        logic [TAG_W-1:0] tg;
        r  = '0;
        ix = rq.addr[IDX_W-1:0];
        tg = rq.addr[ADDR_W-1:IDX_W];
        if (rq.action == ACT_LOOKUP) begin
            r = stride_table_lookup(rq.addr);
        end else begin
            if (rq.wp) begin
                pt_conf[ix] = rq.pc ? conf_bump(pt_conf[ix]) : '0;
            end else if (pt_tag[ix] == tg) begin
                pt_conf[ix] = conf_bump(pt_conf[ix]);
            end else begin
                pt_tag[ix]  = tg;
                pt_conf[ix] = '0;
            end
            pt_stride[ix] = rq.tv - pt_last[ix];
            pt_last[ix]   = rq.tv;
        end
        return r;
    endfunction

    // called at the step of the previous acceptance (or later)
    task automatic send_req(input t_vp_req rq, input logic typed, input t_vp_result typed_res);
        int         gap;
        t_vp_result res;
        gap = send_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_action             <= rq.action;
        i_inst_addr          <= rq.addr;
        i_was_predicted      <= rq.wp;
        i_prediction_correct <= rq.pc;
        i_true_value         <= rq.tv;
        do @(posedge i_clk); while (o_stall);
        res = stride_table_step(rq);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic dir_row(input logic act, input logic [ADDR_W-1:0] addr, input logic wp,
                           input logic pc, input logic [VAL_W-1:0] tv, input logic typed,
                           input logic pv, input logic [VAL_W-1:0] val);
        t_dir_row row;
        row.rq.action = act;
        row.rq.addr   = addr;
        row.rq.wp     = wp;
        row.rq.pc     = pc;
        row.rq.tv     = tv;
        row.typed     = typed;
        row.res.pv    = pv;
        row.res.val   = val;
        dir_tab.push_back(row);
    endtask

    // request side
    initial begin : request_drive
        logic [ADDR_W-1:0] amax;
        logic [ADDR_W-1:0] alias_max;
        logic [ADDR_W-1:0] pool [POOL_N];
        logic [IDX_W-1:0]  sidx [3];
        logic [ADDR_W-1:0] a;
        logic [VAL_W-1:0]  v;
        logic [VAL_W-1:0]  stride;
        t_vp_req           rq;
        t_vp_result        peek;
        t_vp_result        none;
        int                n_sent;
        int                len;
        bit                drained;

        i_rst_n              <= 1'b0;
        i_valid              <= 1'b0;
        i_action             <= ACT_LOOKUP;
        i_inst_addr          <= '0;
        i_was_predicted      <= 1'b0;
        i_prediction_correct <= 1'b0;
        i_true_value         <= '0;
        for (int k = 0; k < ENTRIES; k++) begin
            pt_tag[k]    = '0;
            pt_conf[k]   = '0;
            pt_last[k]   = '0;
            pt_stride[k] = '0;
        end
        none      = '0;
        amax      = '1;
        alias_max = {{(TAG_W/2){2'b01}}, {IDX_W{1'b1}}};

        // fresh table, then build confidence on address 5
        dir_row(ACT_LOOKUP, 64'd0, 1'b0, 1'b0, 64'd0, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, amax, 1'b1, 1'b1, '1, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd5, 1'b0, 1'b0, 64'd100, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd5, 1'b0, 1'b0, 64'd110, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd5, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd5, 1'b0, 1'b0, 64'd120, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd5, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        // saturation, then a wrong prediction clears the counter
        dir_row(ACT_UPDATE, 64'd5, 1'b1, 1'b1, 64'd130, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd5, 1'b1, 1'b0, '1, 1'b0, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd5, 1'b1, 1'b0, 64'd0, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd5, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        // top address: tag miss, then wrap of value and stride
        dir_row(ACT_UPDATE, amax, 1'b0, 1'b0, '1, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, amax, 1'b0, 1'b0, 64'd0, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, amax, 1'b0, 1'b0, 64'd1, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, amax, 1'b0, 1'b0, 64'd2, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, amax, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        // same index, other tag: no hit, then replacement evicts the top address
        dir_row(ACT_LOOKUP, alias_max, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, alias_max, 1'b0, 1'b0, 64'd7, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, amax, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0, 64'd0);
        // negative stride wraps the prediction
        dir_row(ACT_UPDATE, 64'd7, 1'b0, 1'b0, '1, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd7, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'd7, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd7, 1'b1, 1'b1, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 64'd0);
        dir_row(ACT_UPDATE, 64'h400, 1'b0, 1'b0, '1, 1'b1, 1'b0, 64'd0);
        dir_row(ACT_LOOKUP, 64'd0, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 64'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) send_req(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].res);

        n_sent  = 0;
        drained = 1'b0;
        while (n_sent < RAND_ITEMS) begin
            if (n_sent % 120 < 2 || n_sent == 0) begin
                // hot addresses: three shared indexes, tag zero and random tags, and the top address
                for (int k = 0; k < 3; k++) sidx[k] = IDX_W'($urandom_range(0, ENTRIES - 1));
                for (int k = 0; k < POOL_N; k++) begin
                    pool[k][IDX_W-1:0]      = sidx[k % 3];
                    pool[k][ADDR_W-1:IDX_W] = (k < 3) ? '0 : TAG_W'({$urandom, $urandom});
                end
                pool[POOL_N-1] = amax;
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise request, every field random
                rq.action = 1'($urandom_range(0, 1));
                rq.addr   = {$urandom, $urandom};
                rq.wp     = 1'($urandom_range(0, 1));
                rq.pc     = 1'($urandom_range(0, 1));
                rq.tv     = {$urandom, $urandom};
                send_req(rq, 1'b0, none);
                n_sent++;
            end else begin
                a = pool[$urandom_range(0, POOL_N - 1)];
                case ($urandom_range(0, 3))
                    0: stride = '0;
                    1: stride = VAL_W'($urandom_range(1, 64));
                    2: stride = -VAL_W'($urandom_range(1, 64));
                    default: stride = {$urandom, $urandom};
                endcase
                v   = $urandom_range(0, 1) ? pt_last[a[IDX_W-1:0]] : {$urandom, $urandom};
                len = $urandom_range(3, 10);
                for (int s = 0; s < len; s++) begin
                    if ($urandom_range(0, 1)) begin
                        rq.action = ACT_LOOKUP;
                        rq.addr   = a;
                        rq.wp     = 1'($urandom_range(0, 1));
                        rq.pc     = 1'($urandom_range(0, 1));
                        rq.tv     = {$urandom, $urandom};
                        send_req(rq, 1'b0, none);
                        n_sent++;
                    end
                    v    = v + stride;
                    peek = stride_table_lookup(a);
                    rq.action = ACT_UPDATE;
                    rq.addr   = a;
                    rq.wp     = peek.pv;
                    rq.pc     = peek.pv && (peek.val == v);
                    rq.tv     = v;
                    // break the run now and then
                    case ($urandom_range(0, 19))
                        0: rq.wp = ~rq.wp;
                        1: rq.pc = ~rq.pc;
                        2: rq.tv = v ^ {$urandom, $urandom};
                        default: ;
                    endcase
                    send_req(rq, 1'b0, none);
                    n_sent++;
                end
            end
            if (n_sent >= 400 && !drained) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 3) == 0) send_quiet = ~send_quiet;
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("stride_value_predictor_core verification clean");
        end else begin
            $display("stride_value_predictor_core verification failed");
        end
        $finish;
    end

    // result side
    initial begin : result_check
        t_vp_result want;
        int         hold;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_predict_valid !== want.pv) begin
                        $error("predict_valid: expected %0d, got %0d", want.pv, o_predict_valid);
                        mismatch_count++;
                    end
                    if (o_predicted_value !== want.val) begin
                        $error("predicted_value: expected %h, got %h",
                               want.val, o_predicted_value);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 49) == 0) recv_quiet = ~recv_quiet;
                hold = recv_quiet ? 0 : $urandom_range(0, 10);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

endmodule

>>> stride_value_predictor_core.f
sv/svp_pkg.sv
sv/svp_front.sv
sv/svp_queue.sv
sv/svp_back.sv
sv/stride_value_predictor_core.sv
sv/svp_checker.sv
tb/tb_stride_value_predictor_core.sv
